// ----- hdl/btn_pkg.sv -----
// Shared types and codes for the binomial tree neighbour block.
// Used by btn_front, btn_queue, btn_back and the top level; no dependencies.
package btn_pkg;

    localparam int GS_W     = 17;
    localparam int RANK_W   = 16;
    localparam int CNT_W    = 5;
    localparam int BIT_W    = 5;
    localparam int TOP_W    = 4;
    localparam int CFG_A_W  = 2;
    localparam int Q_DEPTH  = 2;

    localparam logic [CFG_A_W-1:0] CFG_GROUP_SIZE     = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_ROOT_RANK      = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_TREE_MODE      = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_CHILD_CAPACITY = 2'd3;

    typedef enum logic [1:0] {
        KIND_PARENT  = 2'd0,
        KIND_CHILD   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BADRANK  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PARENT,
        BK_SCAN,
        BK_SUMMARY
    } t_bk_state;

    typedef struct packed {
        logic              bad;
        logic [RANK_W-1:0] vself;
        logic [TOP_W-1:0]  top;
    } t_job;

    typedef struct packed {
        logic [GS_W-1:0]   group_size;
        logic [RANK_W-1:0] root_rank;
        logic              tree_mode;
        logic [CNT_W-1:0]  child_capacity;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [RANK_W-1:0] rank;
        logic [CNT_W-1:0]  count;
        logic              has_parent;
        t_status           status;
        logic              last;
    } t_result;

endpackage

// ----- hdl/btn_front.sv -----
// Front end: checks a query against the group configuration and makes it root-relative.
// Depends on btn_pkg.
module btn_front (
    input  btn_pkg::t_cfg  i_cfg,
    input  logic [15:0]    i_self_rank,
    output btn_pkg::t_job  o_job
);
    import btn_pkg::*;

    localparam logic [32:0] SIZE_LIMIT = 33'(1) << RANK_W;

    logic [GS_W-1:0]  self_ext;
    logic [GS_W-1:0]  root_ext;
    logic [GS_W-1:0]  rel;
    logic [TOP_W-1:0] top;

    always_comb begin
        self_ext = GS_W'(i_self_rank);
        root_ext = GS_W'(i_cfg.root_rank);
        if (self_ext >= root_ext) begin
            rel = self_ext - root_ext;
        end else begin
            rel = self_ext + i_cfg.group_size - root_ext;
        end

        // Highest set bit of the relative rank; only meaningful when it is nonzero.
        top = '0;
        for (int i = 0; i < RANK_W; i++) begin
            if (rel[i]) begin
                top = TOP_W'(i);
            end
        end

        o_job.bad   = (i_cfg.group_size == '0) ||
                      (33'(i_cfg.group_size) > SIZE_LIMIT) ||
                      (self_ext >= i_cfg.group_size) ||
                      (root_ext >= i_cfg.group_size);
        o_job.vself = rel[RANK_W-1:0];
        o_job.top   = top;
    end

endmodule

// ----- hdl/btn_queue.sv -----
// Two-entry job queue between the front and back ends.
// Depends on btn_pkg.
module btn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  btn_pkg::t_job i_job,
    input  logic          i_pop,
    output btn_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import btn_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    t_job              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_QW-1:0] r_count;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_QW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= wrap_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= wrap_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

// ----- hdl/btn_back.sv -----
// Back end: walks the bits of one queued rank and emits parent, child and summary items.
// Depends on btn_pkg; owns the output register.
module btn_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  btn_pkg::t_cfg    i_cfg,
    input  btn_pkg::t_job    i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output btn_pkg::t_result o_out
);
    import btn_pkg::*;

    t_bk_state         r_state, n_state;
    logic [RANK_W-1:0] r_vself, n_vself;
    logic [TOP_W-1:0]  r_top, n_top;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_par, n_par;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              adv;
    logic [GS_W-1:0]   mask;
    logic [GS_W-1:0]   vs_ext;
    logic [GS_W-1:0]   cand;
    logic [GS_W-1:0]   rot_sum;
    logic [RANK_W-1:0] rot;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vself  <= n_vself;
        r_top    <= n_top;
        r_bit    <= n_bit;
        r_cnt    <= n_cnt;
        r_par    <= n_par;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_comb begin
        adv    = !r_out_valid || i_out_ready;
        mask   = GS_W'(1) << r_bit;
        vs_ext = GS_W'(r_vself);

        // Candidate neighbour for this step, then rotated back by the root.
        if (r_state == BK_PARENT) begin
            cand = vs_ext ^ (GS_W'(1) << r_top);
        end else begin
            cand = vs_ext ^ mask;
        end
        rot_sum = cand + GS_W'(i_cfg.root_rank);
        if (rot_sum >= i_cfg.group_size) begin
            rot_sum = rot_sum - i_cfg.group_size;
        end
        rot = rot_sum[RANK_W-1:0];

        n_state     = r_state;
        n_vself     = r_vself;
        n_top       = r_top;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_par       = r_par;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;

        n_out.kind       = KIND_CHILD;
        n_out.rank       = rot;
        n_out.count      = '0;
        n_out.has_parent = 1'b0;
        n_out.status     = ST_OK;
        n_out.last       = 1'b0;
        if (!(adv && !r_out_valid) && r_out_valid && !i_out_ready) begin
            n_out = r_out;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_vself  = i_job.vself;
                    n_top    = i_job.top;
                    n_bit    = '0;
                    n_cnt    = '0;
                    n_par    = 1'b0;
                    if (i_job.bad) begin
                        n_status = ST_BADRANK;
                        n_state  = BK_SUMMARY;
                    end else begin
                        n_status = ST_OK;
                        n_state  = i_cfg.tree_mode ? BK_SCAN : BK_PARENT;
                    end
                end
            end
            BK_PARENT: begin
                if (r_vself == '0) begin
                    n_bit   = '0;
                    n_state = BK_SCAN;
                end else if (adv) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = KIND_PARENT;
                    n_par       = 1'b1;
                    n_bit       = BIT_W'(r_top) + BIT_W'(1);
                    n_state     = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (mask >= i_cfg.group_size) begin
                    n_state = BK_SUMMARY;
                end else if (i_cfg.tree_mode && ((vs_ext & mask) != '0)) begin
                    // First set bit from the bottom: parent, and the scan ends.
                    if (adv) begin
                        n_out_valid = 1'b1;
                        n_out.kind  = KIND_PARENT;
                        n_par       = 1'b1;
                        n_state     = BK_SUMMARY;
                    end
                end else if (cand >= i_cfg.group_size) begin
                    if (i_cfg.tree_mode) begin
                        n_bit = r_bit + BIT_W'(1);
                    end else begin
                        n_state = BK_SUMMARY;
                    end
                end else if (r_cnt == i_cfg.child_capacity) begin
                    n_status = ST_OVERFLOW;
                    n_state  = BK_SUMMARY;
                end else if (adv) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = KIND_CHILD;
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_bit       = r_bit + BIT_W'(1);
                end
            end
            BK_SUMMARY: begin
                if (adv) begin
                    n_out_valid      = 1'b1;
                    n_out.kind       = KIND_SUMMARY;
                    n_out.rank       = '0;
                    n_out.count      = r_cnt;
                    n_out.has_parent = r_par;
                    n_out.status     = r_status;
                    n_out.last       = 1'b1;
                    n_state          = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        // A held result stays put while the consumer stalls.
        if (!adv) begin
            n_out = r_out;
        end
    end

endmodule

// ----- hdl/binomial_tree_neighbours_core.sv -----
// Top level of the binomial tree neighbour block: configuration registers,
// front end, job queue and back end. Depends on btn_pkg, btn_front, btn_queue, btn_back.
//
//   channel   handshake                   payload
//   query     i_in_valid / o_in_ready     i_self_rank
//   result    o_out_valid / i_out_ready   o_entry_kind .. o_last
//   config    i_cfg_we (no wait)          i_cfg_addr, i_cfg_data
//
// A query is checked and made root-relative in the cycle it is accepted and waits
// in a two-entry queue. The back end dequeues a job, scans the bit positions in
// turn for the parent and child items, including the position that ends the scan,
// then emits the summary; a bad rank goes straight from dequeue to summary, and a
// stalled consumer holds the scan. Reset is synchronous and active low and
// empties the queue and output register. Queries are accepted while the queue has
// room, even while a result waits on a stalled consumer.
module binomial_tree_neighbours_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [btn_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [btn_pkg::GS_W-1:0]      i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [15:0]                   i_self_rank,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_entry_kind,
    output logic [15:0]                   o_neighbour_rank,
    output logic [4:0]                    o_child_count,
    output logic                          o_has_parent,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import btn_pkg::*;

    t_cfg    r_cfg;
    t_job    front_job;
    t_job    queue_job;
    t_result result;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.group_size     <= GS_W'(1);
            r_cfg.root_rank      <= '0;
            r_cfg.tree_mode      <= 1'b0;
            r_cfg.child_capacity <= CNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GROUP_SIZE:     r_cfg.group_size     <= i_cfg_data;
                CFG_ROOT_RANK:      r_cfg.root_rank      <= i_cfg_data[RANK_W-1:0];
                CFG_TREE_MODE:      r_cfg.tree_mode      <= i_cfg_data[0];
                CFG_CHILD_CAPACITY: r_cfg.child_capacity <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    btn_front u_front (
        .i_cfg       (r_cfg),
        .i_self_rank (i_self_rank),
        .o_job       (front_job)
    );

    btn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (queue_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    btn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (queue_job),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (result)
    );

    assign o_entry_kind     = result.kind;
    assign o_neighbour_rank = result.rank;
    assign o_child_count    = result.count;
    assign o_has_parent     = result.has_parent;
    assign o_status         = result.status;
    assign o_last           = result.last;

    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_entry_kind == KIND_SUMMARY)))
        else $error("last flag does not match summary kind");

    a_neighbour_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_child_count == '0 && o_status == ST_OK &&
                                      !o_has_parent))
        else $error("summary fields set on a neighbour item");

    a_ok_within_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && o_status == ST_OK) |->
            (o_child_count <= r_cfg.child_capacity))
        else $error("ok summary reports more children than capacity");

    a_badrank_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BADRANK) |->
            (o_child_count == '0 && !o_has_parent && o_neighbour_rank == '0))
        else $error("bad-rank summary carries neighbour data");

endmodule
